// ===== sv/swarq_pkg.sv =====
// shared types, codes and constants of the stop-and-wait arq controller
package swarq_pkg;

  localparam int SEQ_W       = 3;
  localparam int TICK_W      = 16;
  localparam int ELAPSED_W   = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int CMDQ_DEPTH  = 4;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX      = '1;
  localparam logic [TICK_W-1:0]    RETX_TICKS_RESET = 16'd1000;
  localparam logic [TICK_W-1:0]    RETRY_DLY_RESET  = 16'd100;

  // event kinds of an incoming request
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_SEND = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  // result actions
  typedef enum logic [2:0] {
    ACT_ACK        = 3'd0,
    ACT_DELIVER    = 3'd1,
    ACT_TRANSMIT   = 3'd2,
    ACT_RETRANSMIT = 3'd3,
    ACT_RETRY      = 3'd4,
    ACT_DONE       = 3'd5
  } action_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RETX_TICKS  = 1'd0,
    REG_RETRY_DELAY = 1'd1
  } reg_idx_t;

  // one classified event: first result, plus an ack with the same seq when pair is set
  typedef struct packed {
    action_t           action;
    logic [SEQ_W-1:0]  seq;
    logic [TICK_W-1:0] delay;
    logic              pair;
  } cmd_t;

endpackage

// ===== sv/stop_wait_arq_controller.sv =====
// top level of the stop-and-wait arq controller with modulo-8 sequence numbers
//
//  channel   handshake              payload
//  event     push / full            kind, frame_seq
//  result    empty / pop            action, seq, delay, last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a request is classified when accepted, one per cycle while full is low; its first result
// is registered in the command queue, a four-entry buffer for bursts, then in the output
// register; results leave one per cycle while popped, a delivery yielding deliver and ack
// rst is synchronous; after it the queue and the output register are empty and full is low
// full rises only while the command queue is full; a stalled pop holds the result
// cfg_ready is always high
module stop_wait_arq_controller #(
  parameter int QUEUE_DEPTH = swarq_pkg::CMDQ_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind,
  input  logic [swarq_pkg::SEQ_W-1:0]     frame_seq,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      action,
  output logic [swarq_pkg::SEQ_W-1:0]     seq,
  output logic [swarq_pkg::TICK_W-1:0]    delay,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swarq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swarq_pkg::TICK_W-1:0]    cfg_data
);
  import swarq_pkg::*;

  logic q_full;
  logic enq;
  cmd_t enq_cmd;
  logic deq;
  logic q_valid;
  cmd_t deq_cmd;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  // event classification and arq state
  swarq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .kind      (kind),
    .frame_seq (frame_seq),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .enq       (enq),
    .enq_cmd   (enq_cmd)
  );

  // command queue
  swarq_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .full    (q_full),
    .deq     (deq),
    .q_valid (q_valid),
    .deq_cmd (deq_cmd)
  );

  // result sequencer
  swarq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .deq_cmd (deq_cmd),
    .deq     (deq),
    .pop     (pop),
    .empty   (empty),
    .action  (action),
    .seq     (seq),
    .delay   (delay),
    .last    (last)
  );

endmodule

// ===== sv/swarq_front.sv =====
// front end: accepts events, keeps the arq state and classifies each event into a command
module swarq_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [1:0]                     kind,
  input  logic [swarq_pkg::SEQ_W-1:0]    frame_seq,
  input  logic                           cfg_valid,
  input  logic [swarq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swarq_pkg::TICK_W-1:0]   cfg_data,
  input  logic                           q_full,
  output logic                           enq,
  output swarq_pkg::cmd_t                enq_cmd
);
  import swarq_pkg::*;

  logic [TICK_W-1:0]    retx_ticks;
  logic [TICK_W-1:0]    retry_dly;
  logic [SEQ_W-1:0]     exp_rx_seq, exp_rx_seq_next;
  logic [SEQ_W-1:0]     tx_seq, tx_seq_next;
  logic                 busy, busy_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [SEQ_W-1:0]     prev_rx_seq;
  logic                 accept;
  logic                 has_result;
  cmd_t                 cmd;

  assign accept      = push && !q_full;
  assign prev_rx_seq = exp_rx_seq - SEQ_W'(1);
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + ELAPSED_W'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retx_ticks <= RETX_TICKS_RESET;
      retry_dly  <= RETRY_DLY_RESET;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_RETX_TICKS:  retx_ticks <= cfg_data;
        REG_RETRY_DELAY: retry_dly  <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the event and work out the next state
  always_comb begin
    exp_rx_seq_next = exp_rx_seq;
    tx_seq_next     = tx_seq;
    busy_next       = busy;
    elapsed_next    = elapsed;
    has_result      = 1'b0;
    cmd.action      = ACT_ACK;
    cmd.seq         = frame_seq;
    cmd.delay       = '0;
    cmd.pair        = 1'b0;
    case (kind_t'(kind))
      KIND_DATA: begin
        if (frame_seq == exp_rx_seq) begin
          has_result      = 1'b1;
          cmd.action      = ACT_DELIVER;
          cmd.pair        = 1'b1;
          exp_rx_seq_next = exp_rx_seq + SEQ_W'(1);
        end else if (frame_seq == prev_rx_seq) begin
          has_result = 1'b1;
        end
      end
      KIND_ACK: begin
        if (frame_seq == tx_seq) begin
          has_result  = 1'b1;
          cmd.action  = ACT_DONE;
          cmd.seq     = tx_seq;
          busy_next   = 1'b0;
          tx_seq_next = tx_seq + SEQ_W'(1);
        end
      end
      KIND_SEND: begin
        has_result = 1'b1;
        if (busy) begin
          cmd.action = ACT_RETRY;
          cmd.seq    = '0;
          cmd.delay  = retry_dly;
        end else begin
          cmd.action   = ACT_TRANSMIT;
          cmd.seq      = tx_seq;
          busy_next    = 1'b1;
          elapsed_next = '0;
        end
      end
      KIND_TICK: begin
        if (busy) begin
          if (elapsed_inc > {1'b0, retx_ticks}) begin
            has_result   = 1'b1;
            cmd.action   = ACT_RETRANSMIT;
            cmd.seq      = tx_seq;
            elapsed_next = '0;
          end else begin
            elapsed_next = elapsed_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // arq state
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_rx_seq <= '0;
      tx_seq     <= '0;
      busy       <= 1'b0;
      elapsed    <= '0;
    end else if (accept) begin
      exp_rx_seq <= exp_rx_seq_next;
      tx_seq     <= tx_seq_next;
      busy       <= busy_next;
      elapsed    <= elapsed_next;
    end
  end

  assign enq     = accept && has_result;
  assign enq_cmd = cmd;

endmodule

// ===== sv/swarq_cmdq.sv =====
// short command queue between the front end and the result sequencer
module swarq_cmdq #(
  parameter int DEPTH = swarq_pkg::CMDQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            enq,
  input  swarq_pkg::cmd_t enq_cmd,
  output logic            full,
  input  logic            deq,
  output logic            q_valid,
  output swarq_pkg::cmd_t deq_cmd
);
  import swarq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_enq;
  logic          do_deq;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign do_enq  = enq && !full;
  assign do_deq  = deq && q_valid;
  assign deq_cmd = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wr_ptr] <= enq_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_enq && !do_deq) begin
        count <= count + CW'(1);
      end else if (!do_enq && do_deq) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== sv/swarq_back.sv =====
// back end: expands commands into results and holds the oldest result in an output register
module swarq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  swarq_pkg::cmd_t             deq_cmd,
  output logic                        deq,
  input  logic                        pop,
  output logic                        empty,
  output logic [2:0]                  action,
  output logic [swarq_pkg::SEQ_W-1:0] seq,
  output logic [swarq_pkg::TICK_W-1:0] delay,
  output logic                        last
);
  import swarq_pkg::*;

  logic             out_valid;
  logic             pending;
  logic [SEQ_W-1:0] pend_seq;
  logic             load;

  // the output register takes a new result when empty or being popped
  assign load  = !out_valid || pop;
  assign deq   = load && !pending && q_valid;
  assign empty = !out_valid;

  // control: output valid and the pending second result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pending   <= deq_cmd.pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        action <= ACT_ACK;
        seq    <= pend_seq;
        delay  <= '0;
        last   <= 1'b1;
      end else if (q_valid) begin
        action   <= deq_cmd.action;
        seq      <= deq_cmd.seq;
        delay    <= deq_cmd.delay;
        last     <= !deq_cmd.pair;
        pend_seq <= deq_cmd.seq;
      end
    end
  end

endmodule

// ===== sv/swarq_checker.sv =====
// port-level checks of the stop-and-wait arq controller, bound to the top level
module swarq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        empty,
  input logic                        pop,
  input logic [2:0]                  action,
  input logic [swarq_pkg::SEQ_W-1:0] seq,
  input logic [swarq_pkg::TICK_W-1:0] delay,
  input logic                        last
);
  import swarq_pkg::*;

  // nothing waits on the result side right after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // a stalled result holds still
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(action) && $stable(seq) && $stable(last)))
    else $error("stalled result changed");

  // only a retry-later carries a delay
  a_delay_retry_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && action != ACT_RETRY) |-> (delay == '0))
    else $error("delay on a result other than retry later");

  // a delivery is never the final result of its request
  a_deliver_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && action == ACT_DELIVER) |-> !last)
    else $error("deliver marked last");

  // a taken delivery is followed at once by its ack with the same sequence
  a_deliver_then_ack: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && action == ACT_DELIVER)
      |=> (!empty && action == ACT_ACK && $stable(seq) && last))
    else $error("deliver not followed by its ack");

endmodule

bind stop_wait_arq_controller swarq_checker u_swarq_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .action (action),
  .seq    (seq),
  .delay  (delay),
  .last   (last)
);
